FILE: design/lattice_bond_energy_defines.svh
// Shared assertion macros for the lattice bond energy block.
`ifndef LATTICE_BOND_ENERGY_DEFINES_SVH
`define LATTICE_BOND_ENERGY_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define LBE_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lattice_bond_energy: check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define LBE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lattice_bond_energy: check failed");

`endif

FILE: design/lbe_pkg.sv
package lbe_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int LABEL_BITS  = 8;
   localparam int COUNT_BITS  = 11;
   localparam int ENERGY_BITS = 22;
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int INDEX_BITS  = 2;

   typedef enum logic [INDEX_BITS-1:0] {
      CSR_ROW_COUNT     = 2'd0,
      CSR_COLUMN_COUNT  = 2'd1,
      CSR_BOUNDARY_MODE = 2'd2
   } csr_index_type;

   // Effective lattice shape: last valid row and column index, wrap enable.
   typedef struct packed {
      logic [ROW_BITS-1:0] rows_last;
      logic [COL_BITS-1:0] cols_last;
      logic                periodic;
   } cfg_type;

   // One cell between the scan stage and the accumulator.
   typedef struct packed {
      logic [LABEL_BITS-1:0] label;
      logic                  prev_check;
      logic                  left_hit;
      logic                  start_hit;
      logic                  wrap_row;
      logic                  row_zero;
      logic                  last;
   } cell_type;

   // Zero acts as one, anything above the limit acts as the limit.
   function automatic logic [COUNT_BITS-1:0] last_index(
      input logic [COUNT_BITS-1:0] count,
      input logic [COUNT_BITS-1:0] limit
   );
      logic [COUNT_BITS-1:0] result;
      result = '0;
      if (count == '0) begin
         result = '0;
      end else if (count > limit) begin
         result = limit - COUNT_BITS'(1);
      end else begin
         result = count - COUNT_BITS'(1);
      end
      return result;
   endfunction

endpackage

FILE: design/lattice_bond_energy.sv
// Potts-model bond energy of a 2-D lattice (coupling 1). Cell labels stream in row-major
// order, one per transfer, and one cell is taken every clock cycle. After the last cell
// of the lattice the block returns energy = -(number of equal-label neighbor pairs),
// 22-bit two's complement. Open mode counts up and left neighbors inside the grid;
// periodic mode also wraps the last column to the row's first cell and the last row to
// the first row. The last cell's transfer loads the input register and the registered
// read of the two 1024-entry row memories; the compare-and-add of that cell is then
// loaded into the output register, whose value drives rsp. The input stalls only while
// a lattice's last cell waits in the input register because the previous result is
// still stalled on rsp. Row count, column count and boundary mode are to be written on
// the csr port between lattices, which the block itself does not enforce; a count of
// zero acts as one and a count above 1024 acts as 1024.
module lattice_bond_energy (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lbe_pkg::LABEL_BITS-1:0]         req_cell_label,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lbe_pkg::ENERGY_BITS-1:0] rsp_lattice_energy,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lbe_pkg::INDEX_BITS-1:0]         csr_index,
   input  logic [lbe_pkg::COUNT_BITS-1:0]         csr_data
);
   import lbe_pkg::*;

   cfg_type               cfg;
   cell_type              s1;
   logic                  s1_valid;
   logic                  hold;
   logic [LABEL_BITS-1:0] prev_rd;
   logic [LABEL_BITS-1:0] first_rd;

   lbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lbe_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_label (req_cell_label),
      .cfg            (cfg),
      .hold           (hold),
      .s1_valid       (s1_valid),
      .s1             (s1),
      .prev_rd        (prev_rd),
      .first_rd       (first_rd)
   );

   lbe_accum u_accum (
      .clock              (clock),
      .reset              (reset),
      .s1_valid           (s1_valid),
      .s1                 (s1),
      .prev_rd            (prev_rd),
      .first_rd           (first_rd),
      .hold               (hold),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lattice_energy (rsp_lattice_energy)
   );

endmodule

FILE: design/lbe_ram.sv
module lbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same address is written.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lbe_csr.sv
module lbe_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lbe_pkg::INDEX_BITS-1:0] csr_index,
   input  logic [lbe_pkg::COUNT_BITS-1:0] csr_data,
   output lbe_pkg::cfg_type              cfg
);
   import lbe_pkg::*;

   localparam logic [COUNT_BITS-1:0] ROW_LIMIT = COUNT_BITS'(MAX_ROWS);
   localparam logic [COUNT_BITS-1:0] COL_LIMIT = COUNT_BITS'(MAX_COLUMNS);

   logic [COUNT_BITS-1:0] row_count_ff;
   logic [COUNT_BITS-1:0] column_count_ff;
   logic                  boundary_mode_ff;
   logic [COUNT_BITS-1:0] rows_last;
   logic [COUNT_BITS-1:0] cols_last;
   logic                  write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= ROW_LIMIT;
         column_count_ff  <= COL_LIMIT;
         boundary_mode_ff <= 1'b0;
      end else if (write) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_COUNT:     row_count_ff     <= csr_data;
            CSR_COLUMN_COUNT:  column_count_ff  <= csr_data;
            CSR_BOUNDARY_MODE: boundary_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign rows_last     = last_index(row_count_ff, ROW_LIMIT);
   assign cols_last     = last_index(column_count_ff, COL_LIMIT);
   assign cfg.rows_last = rows_last[ROW_BITS-1:0];
   assign cfg.cols_last = cols_last[COL_BITS-1:0];
   assign cfg.periodic  = boundary_mode_ff;

endmodule

FILE: design/lbe_scan.sv
module lbe_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lbe_pkg::LABEL_BITS-1:0] req_cell_label,
   input  lbe_pkg::cfg_type              cfg,
   input  logic                          hold,
   output logic                          s1_valid,
   output lbe_pkg::cell_type             s1,
   output logic [lbe_pkg::LABEL_BITS-1:0] prev_rd,
   output logic [lbe_pkg::LABEL_BITS-1:0] first_rd
);
   import lbe_pkg::*;

   `include "lattice_bond_energy_defines.svh"

   logic [COL_BITS-1:0]   col_pos_ff;
   logic [COL_BITS-1:0]   col_pos_in;
   logic [ROW_BITS-1:0]   row_pos_ff;
   logic [ROW_BITS-1:0]   row_pos_in;
   logic [LABEL_BITS-1:0] left_ff;
   logic [LABEL_BITS-1:0] row_start_ff;
   logic [LABEL_BITS-1:0] start_label;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   cell_type              s1_ff;
   cell_type              s1_in;
   logic                  accept;
   logic                  last_col;
   logic                  last_row;

   assign req_stall = s1_valid_ff && hold;
   assign accept    = req_valid && !req_stall;
   assign last_col  = col_pos_ff >= cfg.cols_last;
   assign last_row  = row_pos_ff >= cfg.rows_last;

   assign start_label = (col_pos_ff == '0) ? req_cell_label : row_start_ff;

   always_comb begin
      s1_in.label      = req_cell_label;
      s1_in.prev_check = row_pos_ff != '0;
      s1_in.left_hit   = (col_pos_ff != '0) && (left_ff == req_cell_label);
      s1_in.start_hit  = cfg.periodic && last_col && (start_label == req_cell_label);
      s1_in.wrap_row   = cfg.periodic && last_row;
      s1_in.row_zero   = row_pos_ff == '0;
      s1_in.last       = last_col && last_row;

      col_pos_in = last_col ? '0 : col_pos_ff + COL_BITS'(1);
      row_pos_in = row_pos_ff;
      if (last_col) begin
         row_pos_in = last_row ? '0 : row_pos_ff + ROW_BITS'(1);
      end

      // Keep a stalled cell in place, otherwise it drains into the accumulator.
      s1_valid_in = accept || (s1_valid_ff && hold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         left_ff      <= '0;
         row_start_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            col_pos_ff   <= col_pos_in;
            row_pos_ff   <= row_pos_in;
            left_ff      <= req_cell_label;
            row_start_ff <= start_label;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   lbe_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_prev_row (
      .clock   (clock),
      .wr_en   (accept),
      .rd_en   (accept),
      .addr    (col_pos_ff),
      .wr_data (req_cell_label),
      .rd_data (prev_rd)
   );

   lbe_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_first_row (
      .clock   (clock),
      .wr_en   (accept && (row_pos_ff == '0)),
      .rd_en   (accept),
      .addr    (col_pos_ff),
      .wr_data (req_cell_label),
      .rd_data (first_rd)
   );

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

   `LBE_ASSERT_NEXT(a_wrap_col, accept && last_col, col_pos_ff == '0)
   `LBE_ASSERT_NOW(a_stall_hold, s1_valid_ff && hold, !accept)
   `LBE_ASSERT_NEXT(a_hold_cell, s1_valid_ff && hold, s1_valid_ff && $stable(s1_ff))

endmodule

FILE: design/lbe_accum.sv
module lbe_accum (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  s1_valid,
   input  lbe_pkg::cell_type                     s1,
   input  logic [lbe_pkg::LABEL_BITS-1:0]         prev_rd,
   input  logic [lbe_pkg::LABEL_BITS-1:0]         first_rd,
   output logic                                  hold,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lbe_pkg::ENERGY_BITS-1:0] rsp_lattice_energy
);
   import lbe_pkg::*;

   `include "lattice_bond_energy_defines.svh"

   logic [ENERGY_BITS-1:0] sum_ff;
   logic [ENERGY_BITS-1:0] sum_in;
   logic [ENERGY_BITS-1:0] total;
   logic [ENERGY_BITS-1:0] energy_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   advance;
   logic                   prev_hit;
   logic                   first_hit;
   logic [2:0]             bonds;

   // Only the closing cell of a lattice waits on a full output register.
   assign hold    = s1_valid && s1.last && rsp_valid_ff && rsp_stall;
   assign advance = s1_valid && !hold;

   assign prev_hit  = s1.prev_check && (prev_rd == s1.label);
   assign first_hit = s1.wrap_row && (s1.row_zero || (first_rd == s1.label));

   assign bonds = {2'b00, prev_hit} + {2'b00, s1.left_hit}
                + {2'b00, s1.start_hit} + {2'b00, first_hit};
   assign total = sum_ff + ENERGY_BITS'(bonds);

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         sum_in = s1.last ? '0 : total;
         if (s1.last) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1.last) begin
         energy_ff <= '0 - total;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lattice_energy = signed'(energy_ff);

   `LBE_ASSERT_NEXT(a_result_out, advance && s1.last, rsp_valid_ff)
   `LBE_ASSERT_NEXT(a_sum_cleared, advance && s1.last, sum_ff == '0)
   `LBE_ASSERT_NOW(a_hold_full, hold, rsp_valid_ff && rsp_stall)

endmodule
